// ----- hdl/iirl_pkg.sv -----
// iirl_pkg: shared types and codes for the indexed insert/remove list
// op and status codes, field widths and the command struct broadcast to the cells
// no dependencies
package iirl_pkg;

    localparam int IDX_W  = 5;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef logic signed [DATA_W-1:0] t_word;

    typedef struct packed {
        logic             en;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] index;
        t_word            value;
    } t_cmd;

endpackage

// ----- hdl/iirl_cell.sv -----
// iirl_cell: one storage slot of the list chain
// holds one word and loads it from the command, the left or the right neighbor
// depends on iirl_pkg
module iirl_cell #(
    parameter int CellPos = 0,
    parameter int CmpW    = 5
) (
    input  logic          i_clk,
    input  iirl_pkg::t_cmd i_cmd,
    input  iirl_pkg::t_word i_left,
    input  iirl_pkg::t_word i_right,
    output iirl_pkg::t_word o_word
);
    import iirl_pkg::*;

    localparam logic [CmpW-1:0] Pos = CmpW'(CellPos);

    t_word           r_word;
    logic [CmpW-1:0] w_idx;

    assign w_idx  = CmpW'(i_cmd.index);
    assign o_word = r_word;

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            unique case (i_cmd.op)
                OP_READ: begin
                    r_word <= r_word;
                end
                OP_WRITE: begin
                    if (Pos == w_idx) begin
                        r_word <= i_cmd.value;
                    end
                end
                OP_INSERT: begin
                    if (Pos == w_idx) begin
                        r_word <= i_cmd.value;
                    end else if (Pos > w_idx) begin
                        r_word <= i_left;
                    end
                end
                OP_REMOVE: begin
                    if (Pos >= w_idx) begin
                        r_word <= i_right;
                    end
                end
                default: begin
                    r_word <= r_word;
                end
            endcase
        end
    end

endmodule

// ----- hdl/indexed_insert_remove_list.sv -----
// indexed_insert_remove_list: ordered word list with indexed read, overwrite,
// insert and remove, built as a chain of iirl_cell slots
// depends on iirl_pkg, iirl_cell
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+-------------------------------------
//   in      | i_in_valid  | o_in_stall  | i_op, i_index, i_value
//   out     | o_out_valid | i_out_stall | o_read_value, o_element_count, o_status
//
// for each word, all cells shift in parallel in the cycle it is taken,
// and the result sits in the output register on the next cycle.
// one new word per cycle while the output side does not stall.
// o_in_stall is high only while a result is held and i_out_stall is high.
// synchronous active-low reset clears the count and the output valid; cell
// contents are not reset.
module indexed_insert_remove_list #(
    parameter int CAPACITY = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [iirl_pkg::OP_W-1:0]       i_op,
    input  logic [iirl_pkg::IDX_W-1:0]      i_index,
    input  logic signed [iirl_pkg::DATA_W-1:0] i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [iirl_pkg::DATA_W-1:0] o_read_value,
    output logic [iirl_pkg::CNT_W-1:0]      o_element_count,
    output logic [iirl_pkg::ST_W-1:0]       o_status
);
    import iirl_pkg::*;

    localparam int CntW  = $clog2(CAPACITY + 1);
    localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CmpW  = (CntW > IDX_W) ? CntW : IDX_W;

    t_word            w_word [CAPACITY];
    t_cmd             w_cmd;
    logic             w_accept;
    logic             w_ok;
    logic [ST_W-1:0]  w_status;
    logic [CmpW-1:0]  w_idx;
    logic [CmpW-1:0]  w_cnt;
    t_word            w_sel;

    logic [CntW-1:0]  r_count;
    logic [CntW-1:0]  n_count;
    t_word            n_read;

    logic             r_out_valid;
    t_word            r_read;
    logic [CNT_W-1:0] r_cnt_out;
    logic [ST_W-1:0]  r_status;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_idx = CmpW'(i_index);
    assign w_cnt = CmpW'(r_count);
    assign w_sel = w_word[AddrW'(w_idx)];

    always_comb begin
        w_status = ST_OK;
        n_count  = r_count;
        n_read   = '0;
        priority if (i_op == OP_INSERT) begin
            priority if (w_idx > w_cnt) begin
                w_status = ST_RANGE;
            end else if (r_count == CntW'(CAPACITY)) begin
                w_status = ST_FULL;
            end else begin
                n_count = r_count + CntW'(1);
            end
        end else if (w_idx >= w_cnt) begin
            w_status = ST_RANGE;
        end else begin
            if (i_op == OP_READ || i_op == OP_REMOVE) begin
                n_read = w_sel;
            end
            if (i_op == OP_REMOVE) begin
                n_count = r_count - CntW'(1);
            end
        end
        w_ok = (w_status == ST_OK);
    end

    assign w_cmd.en    = w_accept && w_ok;
    assign w_cmd.op    = i_op;
    assign w_cmd.index = i_index;
    assign w_cmd.value = i_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_word w_left;
        t_word w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_word[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_word[g+1];
        end
        iirl_cell #(
            .CellPos (g),
            .CmpW    (CmpW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_word[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read    <= n_read;
            r_cnt_out <= CNT_W'(n_count);
            r_status  <= w_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_value    = r_read;
    assign o_element_count = r_cnt_out;
    assign o_status        = r_status;

endmodule

// ----- hdl/iirl_checker.sv -----
// iirl_checker: port-level checks for indexed_insert_remove_list
// bound to the top level; depends on iirl_pkg
module iirl_checker #(
    parameter int CAPACITY = 16
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic signed [iirl_pkg::DATA_W-1:0] o_read_value,
    input logic [iirl_pkg::CNT_W-1:0]      o_element_count,
    input logic [iirl_pkg::ST_W-1:0]       o_status
);
    import iirl_pkg::*;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_read_value == '0)
        else $error("error result carries a nonzero word");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_element_count == CNT_W'(CAPACITY))
        else $error("full status with count below capacity");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && CAPACITY < 32 |-> o_element_count <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted word gave no result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_value)
            && $stable(o_element_count) && $stable(o_status))
        else $error("stalled result changed");

endmodule

bind indexed_insert_remove_list iirl_checker #(.CAPACITY(CAPACITY)) u_iirl_checker (.*);
